// File: hdl/bvm_pkg.sv
`timescale 1ns / 1ps
package bvm_pkg;
    localparam logic [1:0] REQ_EXEC = 2'd0;
    localparam logic [1:0] REQ_MWR  = 2'd1;
    localparam logic [1:0] REQ_MRD  = 2'd2;
    localparam logic [1:0] REQ_ROW  = 2'd3;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [11:0] ADDR_MASK = 12'hFFF;
    localparam logic [15:0] FONT_BASE = 16'h0050;
    localparam logic [7:0] SPR_MSB = 8'h80;
    localparam logic [7:0] FN_SKP  = 8'h9E;
    localparam logic [7:0] FN_SKNP = 8'hA1;
    localparam logic [7:0] FN_WKEY = 8'h0A;
    localparam logic [7:0] FN_ADDI = 8'h1E;
    localparam logic [7:0] FN_BCD  = 8'h33;
    localparam logic [7:0] FN_STR  = 8'h55;
    localparam logic [7:0] FN_LDR  = 8'h65;
    localparam logic [7:0] FN_GDLY = 8'h07;
    localparam logic [7:0] FN_SDLY = 8'h15;
    localparam logic [7:0] FN_SSND = 8'h18;
    localparam logic [7:0] FN_FONT = 8'h29;

    // alu op codes for the shared unit
    localparam logic [2:0] ALU_OR  = 3'd0;
    localparam logic [2:0] ALU_AND = 3'd1;
    localparam logic [2:0] ALU_XOR = 3'd2;
    localparam logic [2:0] ALU_ADD = 3'd3;
    localparam logic [2:0] ALU_SUB = 3'd4;
    localparam logic [2:0] ALU_SHR = 3'd5;
    localparam logic [2:0] ALU_SHL = 3'd6;
    localparam logic [2:0] ALU_PASS = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } alu_rsp_t;
endpackage

// File: hdl/byte_vm_instruction_executor_unit.sv
`timescale 1ns / 1ps
// Executes one 16-bit opcode per execute request, or serves a memory byte
// write/read or a display row read. One request is taken at a time; ready
// drops while it runs. BCD repeatedly subtracts 100, then 10, and stores
// each digit; the ones digit is the remainder. Block store writes V0 through
// Vx to memory, one register per memory write. Block load reads each
// register from memory, then writes it back. A sprite draw reads each sprite
// row from memory, then xors it into the display row. A display clear walks
// all display rows. The byte memory and the 8-bit alu set these step
// sequences. After reset a pass over all display rows clears the display
// before the first request.
module byte_vm_instruction_executor_unit
    import bvm_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int MEM_BYTES   = 4096,
    parameter int SCREEN_W    = 64,
    parameter int SCREEN_H    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] opcode,
    input  logic [15:0] key_mask,
    input  logic [7:0]  random_byte,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [4:0]  row_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_pc,
    output logic [SCREEN_W-1:0] read_data,
    output logic [7:0]  flag_value,
    output logic        key_waiting
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int HW = $clog2(SCREEN_H);
    localparam int XW = $clog2(SCREEN_W);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_EXEC = 4'd2;
    localparam logic [3:0] S_MRD  = 4'd3;
    localparam logic [3:0] S_DRAW = 4'd4;
    localparam logic [3:0] S_DXOR = 4'd5;
    localparam logic [3:0] S_BCD  = 4'd6;
    localparam logic [3:0] S_STR  = 4'd7;
    localparam logic [3:0] S_LDR  = 4'd8;
    localparam logic [3:0] S_LDW  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_CLS  = 4'd12;

    logic [3:0]  state_reg;
    logic        super_reg;
    logic [7:0]  v_reg [16];
    logic [15:0] i_reg, pc_reg;
    logic [15:0] stk [STACK_DEPTH];
    logic [SW-1:0] sp_reg;
    logic [7:0]  dly_reg, snd_reg;
    logic [4:0]  pend_reg;
    logic [7:0]  mem [MEM_BYTES];
    logic [SCREEN_W-1:0] scr [SCREEN_H];

    // latched request
    logic [1:0]  rt_reg;
    logic [15:0] op_reg, keys_reg;
    logic [7:0]  rnd_reg;
    logic [11:0] ma_reg;
    logic [7:0]  md_reg;
    logic [4:0]  rs_reg;

    // sequencing
    logic [4:0]  cnt_reg;
    logic [7:0]  work_reg;
    logic [1:0]  dig_reg;
    logic [7:0]  hund_reg, tens_reg;
    logic        wait_reg;
    logic [7:0]  mrd_reg;
    logic [XW-1:0] xp_reg;
    logic [HW-1:0] yp_reg;

    logic [3:0] ox, oy, on;
    logic [7:0] onn, vx, vy;
    assign ox = op_reg[11:8];
    assign oy = op_reg[7:4];
    assign on = op_reg[3:0];
    assign onn = op_reg[7:0];
    assign vx = v_reg[ox];
    assign vy = v_reg[oy];

    // stack level wraps at the stack depth
    logic [SW-1:0] sp_inc, sp_dec;
    assign sp_inc = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + SW'(1);
    assign sp_dec = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - SW'(1);

    // draw geometry, captured before the flag register is cleared
    logic [XW-1:0] xp;
    logic [HW-1:0] yp;
    logic [HW:0]   yrow;
    assign xp = xp_reg;
    assign yp = yp_reg;
    assign yrow = {1'b0, yp} + {1'b0, cnt_reg[HW-1:0]};

    // shared alu
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    bvm_alu u_alu (.req(alu_req), .rsp(alu_rsp));

    always_comb
    begin
        alu_req = '{op: ALU_PASS, a: vx, b: vy};
        if (state_reg == S_BCD)
            alu_req = '{op: ALU_SUB, a: work_reg, b: (dig_reg == 2'd0) ? 8'd100 : 8'd10};
        else
        begin
            case (on)
                4'h1: alu_req.op = ALU_OR;
                4'h2: alu_req.op = ALU_AND;
                4'h3: alu_req.op = ALU_XOR;
                4'h4: alu_req.op = ALU_ADD;
                4'h5: alu_req.op = ALU_SUB;
                4'h7: alu_req = '{op: ALU_SUB, a: vy, b: vx};
                4'h6: alu_req = '{op: ALU_SHR, a: super_reg ? vx : vy, b: vy};
                4'hE: alu_req = '{op: ALU_SHL, a: super_reg ? vx : vy, b: vy};
                default: alu_req.op = ALU_PASS;
            endcase
        end
    end

    // memory port, one access a cycle
    logic        mwe;
    logic [AW-1:0] maddr;
    logic [7:0]  mwd;
    logic [15:0] ioff;
    assign ioff = i_reg + {11'd0, cnt_reg};

    always_comb
    begin
        mwe = 1'b0;
        maddr = ioff[AW-1:0];
        mwd = v_reg[cnt_reg[3:0]];
        unique case (state_reg)
            S_IDLE:
            begin
                maddr = mem_address[AW-1:0];
                mwd = mem_data;
                mwe = in_valid && req_type == REQ_MWR;
            end
            S_STR: mwe = 1'b1;
            S_BCD:
            begin
                if (dig_reg == 2'd2)
                begin
                    mwe = 1'b1;
                    mwd = work_reg;
                end
                else if (alu_rsp.flag == 1'b0 && cnt_reg == 5'd0)
                begin
                    // digit done: store it
                    mwe = 1'b1;
                    mwd = (dig_reg == 2'd0) ? hund_reg : tens_reg;
                end
                maddr = (i_reg[AW-1:0] + {{(AW-2){1'b0}}, dig_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[maddr] <= mwd;
        if (state_reg == S_IDLE)
            mrd_reg <= mem[mem_address[AW-1:0]];
        else if (state_reg == S_MRD)
            mrd_reg <= mem[ma_reg[AW-1:0]];
        else
            mrd_reg <= mem[ioff[AW-1:0]];
    end

    logic in_fire;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;

    // key wait helper
    logic [4:0] first_key;
    always_comb
    begin
        first_key = 5'd0;
        for (int k = 15; k >= 0; k--)
            if (keys_reg[k])
                first_key = 5'(k + 1);
    end

    logic [15:0] pc2;
    assign pc2 = pc_reg + 16'd2;

    // sprite row xor
    logic [SCREEN_W-1:0] spr_mask;
    assign spr_mask = ({mrd_reg, {(SCREEN_W-8){1'b0}}}) >> xp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            super_reg <= 1'b0;
            for (int r = 0; r < 16; r++)
                v_reg[r] <= 8'd0;
            i_reg <= 16'd0;
            pc_reg <= 16'h0200;
            sp_reg <= '0;
            dly_reg <= 8'd0;
            snd_reg <= 8'd0;
            pend_reg <= 5'd0;
            cnt_reg <= 5'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                super_reg <= cfg_wdata;
            unique case (state_reg)
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(SCREEN_H - 1))
                    begin
                        cnt_reg <= 5'd0;
                        state_reg <= S_IDLE;
                    end
                end
                S_CLS:
                begin
                    // clear screen instruction, answers when all rows are done
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(SCREEN_H - 1))
                    begin
                        cnt_reg <= 5'd0;
                        state_reg <= S_DONE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cnt_reg <= 5'd0;
                        wait_reg <= 1'b0;
                        unique case (req_type)
                            REQ_EXEC: state_reg <= S_EXEC;
                            REQ_MRD:  state_reg <= S_MRD;
                            default:  state_reg <= S_DONE;
                        endcase
                    end
                end
                S_EXEC:
                begin
                    pc_reg <= pc2;
                    state_reg <= S_DONE;
                    unique case (op_reg[15:12])
                        4'h0:
                        begin
                            if (op_reg == OP_CLS)
                                state_reg <= S_CLS;
                            else if (op_reg == OP_RET)
                            begin
                                pc_reg <= stk[sp_dec];
                                sp_reg <= sp_dec;
                            end
                        end
                        4'h1: pc_reg <= {4'd0, op_reg[11:0]};
                        4'h2:
                        begin
                            sp_reg <= sp_inc;
                            pc_reg <= {4'd0, op_reg[11:0]};
                        end
                        4'h3: if (vx == onn) pc_reg <= pc_reg + 16'd4;
                        4'h4: if (vx != onn) pc_reg <= pc_reg + 16'd4;
                        4'h5: if (vx == vy) pc_reg <= pc_reg + 16'd4;
                        4'h9: if (vx != vy) pc_reg <= pc_reg + 16'd4;
                        4'h6: v_reg[ox] <= onn;
                        4'h7: v_reg[ox] <= vx + onn;
                        4'h8:
                        begin
                            unique case (on)
                                4'h0: v_reg[ox] <= vy;
                                4'h1, 4'h2, 4'h3:
                                begin
                                    v_reg[ox] <= alu_rsp.res;
                                    if (!super_reg)
                                        v_reg[15] <= 8'd0;
                                end
                                4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                                begin
                                    v_reg[ox] <= alu_rsp.res;
                                    v_reg[15] <= {7'd0, alu_rsp.flag};
                                end
                                default: ;
                            endcase
                        end
                        4'hA: i_reg <= {4'd0, op_reg[11:0]};
                        4'hB: pc_reg <= {4'd0, op_reg[11:0]}
                                        + {8'd0, super_reg ? vx : v_reg[0]};
                        4'hC: v_reg[ox] <= rnd_reg & onn;
                        4'hD:
                        begin
                            xp_reg <= vx[XW-1:0];
                            yp_reg <= vy[HW-1:0];
                            v_reg[15] <= 8'd0;
                            state_reg <= S_DRAW;
                        end
                        4'hE:
                        begin
                            if (onn == FN_SKP && keys_reg[vx[3:0]])
                                pc_reg <= pc_reg + 16'd4;
                            else if (onn == FN_SKNP && !keys_reg[vx[3:0]])
                                pc_reg <= pc_reg + 16'd4;
                        end
                        default:
                        begin
                            case (onn)
                                FN_GDLY: v_reg[ox] <= dly_reg;
                                FN_SDLY: dly_reg <= vx;
                                FN_SSND: snd_reg <= vx;
                                FN_ADDI:
                                begin
                                    if ((i_reg + {8'd0, vx}) > {4'd0, ADDR_MASK})
                                    begin
                                        v_reg[15] <= 8'd1;
                                        i_reg <= (i_reg + {8'd0, vx}) & {4'd0, ADDR_MASK};
                                    end
                                    else
                                        i_reg <= i_reg + {8'd0, vx};
                                end
                                FN_WKEY:
                                begin
                                    if (pend_reg == 5'd0)
                                    begin
                                        pend_reg <= first_key;
                                        pc_reg <= pc_reg;
                                        wait_reg <= 1'b1;
                                    end
                                    else if (keys_reg[pend_reg[3:0] - 4'd1])
                                    begin
                                        pc_reg <= pc_reg;
                                        wait_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        v_reg[ox] <= {4'd0, pend_reg[3:0] - 4'd1};
                                        pend_reg <= 5'd0;
                                    end
                                end
                                FN_FONT: i_reg <= FONT_BASE + 16'(vx) * 16'd5;
                                FN_BCD:
                                begin
                                    work_reg <= vx;
                                    dig_reg <= 2'd0;
                                    hund_reg <= 8'd0;
                                    tens_reg <= 8'd0;
                                    state_reg <= S_BCD;
                                end
                                FN_STR: state_reg <= S_STR;
                                FN_LDR: state_reg <= S_LDR;
                                default: ;
                            endcase
                        end
                    endcase
                end
                S_MRD: state_reg <= S_DONE;
                S_DRAW:
                begin
                    // memory read of sprite row cnt_reg in flight
                    if (cnt_reg[3:0] >= on || yrow[HW])
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_DXOR;
                end
                S_DXOR:
                begin
                    if ((scr[yrow[HW-1:0]] & spr_mask) != '0)
                        v_reg[15] <= 8'd1;
                    cnt_reg <= cnt_reg + 5'd1;
                    state_reg <= S_DRAW;
                end
                S_BCD:
                begin
                    // repeated subtract of 100 then 10; ones digit is remainder
                    if (dig_reg == 2'd2)
                        state_reg <= S_DONE;
                    else if (alu_rsp.flag)
                    begin
                        work_reg <= alu_rsp.res;
                        if (dig_reg == 2'd0)
                            hund_reg <= hund_reg + 8'd1;
                        else
                            tens_reg <= tens_reg + 8'd1;
                    end
                    else if (cnt_reg == 5'd0)
                        dig_reg <= dig_reg + 2'd1;
                end
                S_STR:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == ox)
                    begin
                        if (!super_reg)
                            i_reg <= i_reg + {12'd0, ox} + 16'd1;
                        state_reg <= S_DONE;
                    end
                end
                S_LDR: state_reg <= S_LDW;
                S_LDW:
                begin
                    v_reg[cnt_reg[3:0]] <= mrd_reg;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == ox)
                    begin
                        if (!super_reg)
                            i_reg <= i_reg + {12'd0, ox} + 16'd1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_LDR;
                end
                S_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // request latch, stack, display and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rt_reg <= req_type;
            op_reg <= opcode;
            keys_reg <= key_mask;
            rnd_reg <= random_byte;
            ma_reg <= mem_address;
            md_reg <= mem_data;
            rs_reg <= row_select;
        end
        if (state_reg == S_EXEC && op_reg[15:12] == 4'h2)
            stk[sp_reg] <= pc2;
        if (state_reg == S_CLR || state_reg == S_CLS)
            scr[cnt_reg[HW-1:0]] <= '0;
        if (state_reg == S_DXOR)
            scr[yrow[HW-1:0]] <= scr[yrow[HW-1:0]] ^ spr_mask;
        if (state_reg == S_DONE)
        begin
            next_pc <= pc_reg;
            flag_value <= v_reg[15];
            key_waiting <= (rt_reg == REQ_EXEC) && wait_reg;
            unique case (rt_reg)
                REQ_MRD: read_data <= {{(SCREEN_W-8){1'b0}}, mrd_reg};
                REQ_ROW: read_data <= scr[rs_reg[HW-1:0]];
                default: read_data <= '0;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{md_reg, SPR_MSB, REQ_MWR};
endmodule

// File: hdl/bvm_alu.sv
`timescale 1ns / 1ps
module bvm_alu
    import bvm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);
    logic [8:0] sum;
    always_comb
    begin
        sum = 9'd0;
        rsp = '0;
        case (req.op)
            ALU_OR:  rsp.res = req.a | req.b;
            ALU_AND: rsp.res = req.a & req.b;
            ALU_XOR: rsp.res = req.a ^ req.b;
            ALU_ADD:
            begin
                sum = {1'b0, req.a} + {1'b0, req.b};
                rsp.res = sum[7:0];
                rsp.flag = sum[8];
            end
            ALU_SUB:
            begin
                sum = {1'b0, req.a} - {1'b0, req.b};
                rsp.res = sum[7:0];
                rsp.flag = ~sum[8];
            end
            ALU_SHR:
            begin
                rsp.res = {1'b0, req.a[7:1]};
                rsp.flag = req.a[0];
            end
            ALU_SHL:
            begin
                rsp.res = {req.a[6:0], 1'b0};
                rsp.flag = req.a[7];
            end
            default: rsp.res = req.a;
        endcase
    end
endmodule
